[rtl/sme_pkg.sv]
// ----------------------------------------------------------------------------
// sme_pkg
// Shared types and constants of the stack machine execute unit: the request
// and response payloads, operation codes and error codes.
// ----------------------------------------------------------------------------
package sme_pkg;

  localparam int unsigned DATA_WIDTH          = 32;
  localparam int unsigned IMM_WIDTH           = 24;
  localparam int unsigned STACK_DEPTH_DEFAULT = 64;
  localparam int unsigned MEM_DEPTH_DEFAULT   = 256;

  typedef enum logic [3:0] {
    OP_NOP    = 4'd0,
    OP_PUSH   = 4'd1,
    OP_POP    = 4'd2,
    OP_JUMP   = 4'd3,
    OP_BRANCH = 4'd4,
    OP_EQ     = 4'd5,
    OP_GT     = 4'd6,
    OP_LT     = 4'd7,
    OP_ADD    = 4'd8,
    OP_SUB    = 4'd9,
    OP_OUT    = 4'd10,
    OP_HALT   = 4'd11
  } op_e;

  typedef enum logic [2:0] {
    ERR_OK        = 3'd0,
    ERR_UNDERFLOW = 3'd1,
    ERR_OVERFLOW  = 3'd2,
    ERR_BAD_ADDR  = 3'd3,
    ERR_HALTED    = 3'd4
  } err_e;

  typedef struct packed {
    logic [3:0]           mode;
    logic                 use_imm;
    logic                 indirect;
    logic [IMM_WIDTH-1:0] immediate;
  } req_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] next_pointer;
    logic                  output_valid;
    logic [DATA_WIDTH-1:0] output_value;
    logic                  halted;
    logic [DATA_WIDTH-1:0] exit_code;
    logic [2:0]            error_code;
  } rsp_t;

endpackage

[rtl/stack_machine_execute_unit.sv]
// ----------------------------------------------------------------------------
// stack_machine_execute_unit
// Executes one decoded stack machine instruction per request against an
// operand stack memory, a data memory, an instruction pointer and a halt flag.
// ----------------------------------------------------------------------------
// After reset the unit clears the data memory, one word per cycle, from
// address zero up to MEM_DEPTH-1; no request is taken during that pass.
// Afterwards an instruction first reads the top two stack words from the
// dual-read stack memory, then computes and writes back. An instruction whose
// operand is read indirectly from the data memory adds that read before the
// write-back. A request is buffered while the previous one executes. A finished
// response waits in an output register, and the next instruction completes
// only once that register is free or is being read in the same cycle.
module stack_machine_execute_unit #(
  parameter int unsigned STACK_DEPTH = sme_pkg::STACK_DEPTH_DEFAULT,
  parameter int unsigned MEM_DEPTH   = sme_pkg::MEM_DEPTH_DEFAULT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sme_pkg::req_t req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output sme_pkg::rsp_t rsp_o
);
  import sme_pkg::*;

  localparam int unsigned SAW = $clog2(STACK_DEPTH);
  localparam int unsigned CW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned MAW = $clog2(MEM_DEPTH);
  localparam int unsigned DW  = DATA_WIDTH;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;
  localparam logic [1:0] ST_MEM   = 2'd3;

  // Control state
  logic [1:0]    state_q, state_d;
  logic          in_full_q, in_full_d;
  logic          out_valid_q, out_valid_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] ip_q, ip_d;
  logic          halt_q, halt_d;
  logic [DW-1:0] exit_q, exit_d;
  logic [MAW-1:0] clr_addr_q;

  // Payload registers
  req_t          in_q, ex_q;
  rsp_t          out_q, out_d;
  logic [CW-1:0] cnt_p_q;
  err_e          fault_p_q;
  logic          mem_oob_q;

  // Memories
  logic [DW-1:0] stack_mem [STACK_DEPTH];
  logic [DW-1:0] data_mem  [MEM_DEPTH];
  logic [DW-1:0] st_rd0_q, st_rd1_q, dm_rd_q;

  logic           issue;
  logic [CW-1:0]  cnt_m1, cnt_m2;
  logic           st_we;
  logic           dm_we, dm_re;
  logic [MAW-1:0] dm_waddr;
  logic [DW-1:0]  dm_wdata;

  // Execute stage
  logic          is_arith, first_pop, second_pop, taken, fetch_cls, need_mem;
  logic          under1, under2, addr_oob, imm_oob;
  logic [CW-1:0] cnt1, cnt2;
  logic [DW-1:0] imm_ext, p1, p2, raw_opnd, b_val, alu_val, exe_val;
  err_e          exe_fault;

  // Finalize
  logic          can_fin, fin_go, in_mem;
  logic [DW-1:0] fin_val;
  logic [CW-1:0] fin_cnt;
  err_e          fin_fault;
  logic          push_op, full;

  assign in_ready_o  = !in_full_q && (state_q != ST_CLEAR);
  assign out_valid_o = out_valid_q;
  assign rsp_o       = out_q;

  assign issue  = (state_q == ST_IDLE) && in_full_q;
  assign cnt_m1 = cnt_q - CW'(1);
  assign cnt_m2 = cnt_q - CW'(2);

  // Pops and operand selection, all from the top two stack words read
  // in the issue cycle.
  assign imm_ext   = DW'(ex_q.immediate);
  assign is_arith  = (ex_q.mode >= OP_EQ) && (ex_q.mode <= OP_SUB);
  assign first_pop = ((ex_q.mode == OP_PUSH || ex_q.mode == OP_JUMP ||
                       ex_q.mode == OP_OUT  || ex_q.mode == OP_HALT) && !ex_q.use_imm) ||
                     ex_q.mode == OP_POP || ex_q.mode == OP_BRANCH || is_arith;
  assign under1    = first_pop && (cnt_q == '0);
  assign p1        = (first_pop && cnt_q != '0) ? st_rd0_q : '0;
  assign cnt1      = (first_pop && cnt_q != '0) ? cnt_m1 : cnt_q;
  assign taken     = (ex_q.mode == OP_BRANCH) && (p1 != '0);
  assign second_pop = !ex_q.use_imm && (is_arith || taken);
  assign under2    = second_pop && (cnt1 == '0);
  assign p2        = (cnt_q >= CW'(2)) ? st_rd1_q : '0;
  assign cnt2      = (second_pop && cnt1 != '0) ? cnt1 - CW'(1) : cnt1;
  assign fetch_cls = ex_q.mode == OP_PUSH || ex_q.mode == OP_JUMP ||
                     ex_q.mode == OP_OUT  || ex_q.mode == OP_HALT || taken;
  assign raw_opnd  = ex_q.use_imm ? imm_ext : ((ex_q.mode == OP_BRANCH) ? p2 : p1);
  assign need_mem  = fetch_cls && ex_q.indirect;
  assign addr_oob  = raw_opnd >= DW'(MEM_DEPTH);
  assign imm_oob   = imm_ext >= DW'(MEM_DEPTH);
  assign b_val     = ex_q.use_imm ? imm_ext : p2;

  always_comb begin
    unique case (ex_q.mode)
      OP_EQ:   alu_val = {{(DW-1){1'b0}}, p1 == b_val};
      OP_GT:   alu_val = {{(DW-1){1'b0}}, p1 >  b_val};
      OP_LT:   alu_val = {{(DW-1){1'b0}}, p1 <  b_val};
      OP_ADD:  alu_val = p1 + b_val;
      default: alu_val = p1 - b_val;
    endcase
  end

  assign exe_val = is_arith ? alu_val : ((ex_q.mode == OP_POP) ? p1 : raw_opnd);

  // The first fault raised in execution order wins.
  always_comb begin
    priority if (under1 || under2) begin
      exe_fault = ERR_UNDERFLOW;
    end else if (need_mem && addr_oob) begin
      exe_fault = ERR_BAD_ADDR;
    end else if (ex_q.mode == OP_POP && imm_oob) begin
      exe_fault = ERR_BAD_ADDR;
    end else begin
      exe_fault = ERR_OK;
    end
  end

  // Write-back, shared by the execute cycle and the memory cycle.
  assign in_mem    = (state_q == ST_MEM);
  assign fin_val   = in_mem ? (mem_oob_q ? '0 : dm_rd_q) : exe_val;
  assign fin_cnt   = in_mem ? cnt_p_q : cnt2;
  assign fin_fault = in_mem ? fault_p_q : exe_fault;
  assign can_fin   = !out_valid_q || out_ready_i;
  assign fin_go    = can_fin && (in_mem ||
                     (state_q == ST_EXEC && (halt_q || !need_mem)));
  assign push_op   = (ex_q.mode == OP_PUSH) || is_arith;
  assign full      = (fin_cnt == CW'(STACK_DEPTH));
  assign st_we     = fin_go && !halt_q && push_op && !full;

  assign dm_re = (state_q == ST_EXEC) && !halt_q && need_mem && !addr_oob;

  always_comb begin
    dm_we    = 1'b0;
    dm_waddr = clr_addr_q;
    dm_wdata = '0;
    if (state_q == ST_CLEAR) begin
      dm_we = 1'b1;
    end else if (fin_go && !in_mem && !halt_q && ex_q.mode == OP_POP && !imm_oob) begin
      dm_we    = 1'b1;
      dm_waddr = imm_ext[MAW-1:0];
      dm_wdata = p1;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_full_d   = in_full_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cnt_d       = cnt_q;
    ip_d        = ip_q;
    halt_d      = halt_q;
    exit_d      = exit_q;
    out_d       = out_q;

    if (in_valid_i && in_ready_o) begin
      in_full_d = 1'b1;
    end

    unique case (state_q)
      ST_CLEAR: begin
        if (clr_addr_q == MAW'(MEM_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_full_q) begin
          in_full_d = 1'b0;
          state_d   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!halt_q && need_mem) begin
          state_d = ST_MEM;
        end else if (fin_go) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        if (fin_go) begin
          state_d = ST_IDLE;
        end
      end
    endcase

    if (fin_go) begin
      out_valid_d = 1'b1;
      if (halt_q) begin
        out_d.next_pointer = ip_q;
        out_d.output_valid = 1'b0;
        out_d.output_value = '0;
        out_d.halted       = 1'b1;
        out_d.exit_code    = exit_q;
        out_d.error_code   = ERR_HALTED;
      end else begin
        cnt_d = st_we ? fin_cnt + CW'(1) : fin_cnt;
        unique case (ex_q.mode)
          OP_JUMP: ip_d = fin_val;
          OP_BRANCH: ip_d = (in_mem || taken) ? fin_val : ip_q + DW'(1);
          OP_HALT: begin
            ip_d   = ip_q;
            halt_d = 1'b1;
            exit_d = fin_val;
          end
          default: ip_d = ip_q + DW'(1);
        endcase
        out_d.next_pointer = ip_d;
        out_d.output_valid = (ex_q.mode == OP_OUT);
        out_d.output_value = (ex_q.mode == OP_OUT) ? fin_val : '0;
        out_d.halted       = halt_d;
        out_d.exit_code    = exit_d;
        out_d.error_code   = (fin_fault == ERR_OK && push_op && full) ? ERR_OVERFLOW
                                                                      : fin_fault;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      in_full_q   <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      ip_q        <= '0;
      halt_q      <= 1'b0;
      exit_q      <= '0;
      clr_addr_q  <= '0;
    end else begin
      state_q     <= state_d;
      in_full_q   <= in_full_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      ip_q        <= ip_d;
      halt_q      <= halt_d;
      exit_q      <= exit_d;
      if (state_q == ST_CLEAR) begin
        clr_addr_q <= clr_addr_q + MAW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= req_i;
    end
    if (issue) begin
      ex_q <= in_q;
    end
    if (fin_go) begin
      out_q <= out_d;
    end
    // Intermediate results held across the data memory read.
    if (state_q == ST_EXEC) begin
      cnt_p_q   <= cnt2;
      fault_p_q <= exe_fault;
      mem_oob_q <= addr_oob;
    end
  end

  // Operand stack: two registered read ports, one write port.
  always_ff @(posedge clk_i) begin
    if (st_we) begin
      stack_mem[fin_cnt[SAW-1:0]] <= fin_val;
    end
    if (issue) begin
      st_rd0_q <= stack_mem[cnt_m1[SAW-1:0]];
      st_rd1_q <= stack_mem[cnt_m2[SAW-1:0]];
    end
  end

  // Data memory: single port.
  always_ff @(posedge clk_i) begin
    if (dm_we) begin
      data_mem[dm_waddr] <= dm_wdata;
    end else if (dm_re) begin
      dm_rd_q <= data_mem[raw_opnd[MAW-1:0]];
    end
  end

endmodule

[rtl/sme_checker.sv]
// ----------------------------------------------------------------------------
// sme_checker
// Port-level checks of the stack machine execute unit, bound to the top level.
// ----------------------------------------------------------------------------
module sme_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input sme_pkg::req_t req_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input sme_pkg::rsp_t rsp_o
);
  import sme_pkg::*;

  logic       in_acc, out_acc;
  logic [2:0] pend_q;
  logic       seen_halt_q;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      seen_halt_q <= 1'b0;
    end else begin
      pend_q <= pend_q + 3'(in_acc) - 3'(out_acc);
      if (out_acc && rsp_o.halted) begin
        seen_halt_q <= 1'b1;
      end
    end
  end

  // Every response belongs to a request that has been taken.
  a_resp_has_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != '0)
    else $error("response without an outstanding request");

  // Once halted, every later response repeats the halt with its error.
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && seen_halt_q |-> rsp_o.halted && rsp_o.error_code == ERR_HALTED)
    else $error("response after halt is not reported as ignored");

  a_no_early_halt_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !seen_halt_q |-> rsp_o.error_code != ERR_HALTED)
    else $error("ignored-after-halt error before any halt");

  a_out_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !rsp_o.output_valid |-> rsp_o.output_value == '0)
    else $error("output value set without an output instruction");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(rsp_o))
    else $error("stalled response changed");

endmodule

bind stack_machine_execute_unit sme_checker u_sme_checker (.*);
